// ===== sv/falling_hammer_contact_step_assert.svh =====
// ----------------------------------------------------------------------------
// Falling hammer contact step: assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef FALLING_HAMMER_CONTACT_STEP_ASSERT_SVH
`define FALLING_HAMMER_CONTACT_STEP_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define FHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define FHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FHC_ASSERT(lbl, prop, msg)
`define FHC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/fhc_pkg.sv =====
// ----------------------------------------------------------------------------
// Falling hammer contact step: package
// Payload types, register indexes, reset values, sequencer types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fhc_pkg;

  typedef struct packed {
    logic               func;
    logic signed [31:0] surface_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] collision_force;
    logic signed [31:0] hammer_position;
    logic signed [31:0] hammer_velocity;
    logic               in_contact;
    logic [23:0]        impact_count;
    logic               running;
  } out_item_t;

  typedef struct packed {
    logic [30:0]        inverse_mass;
    logic signed [31:0] gravity;
    logic [16:0]        damping;
    logic [30:0]        hardness;
    logic signed [31:0] drop_height;
    logic signed [31:0] start_velocity;
    logic [23:0]        impact_limit;
  } cfg_t;

  localparam logic [2:0] REG_INVERSE_MASS   = 3'd0;
  localparam logic [2:0] REG_GRAVITY        = 3'd1;
  localparam logic [2:0] REG_DAMPING        = 3'd2;
  localparam logic [2:0] REG_HARDNESS       = 3'd3;
  localparam logic [2:0] REG_DROP_HEIGHT    = 3'd4;
  localparam logic [2:0] REG_START_VELOCITY = 3'd5;
  localparam logic [2:0] REG_IMPACT_LIMIT   = 3'd6;

  localparam logic [30:0]        RST_INVERSE_MASS   = 31'd6554;
  localparam logic signed [31:0] RST_GRAVITY        = 32'sd65536;
  localparam logic [16:0]        RST_DAMPING        = 17'd65536;
  localparam logic [30:0]        RST_HARDNESS       = 31'd65536;
  localparam logic signed [31:0] RST_DROP_HEIGHT    = 32'sd1310720;
  localparam logic signed [31:0] RST_START_VELOCITY = 32'sd0;
  localparam logic [23:0]        RST_IMPACT_LIMIT   = 24'd9999999;

  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
  localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_COLL,
    S_SAT_COLL,
    S_MUL_MASS,
    S_SAT_VEL,
    S_MUL_DAMP,
    S_SAT_DAMP,
    S_POS,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_COLL,
    MUL_MASS,
    MUL_DAMP
  } mul_sel_t;

  typedef struct packed {
    logic accept;
    logic tick_run;
    logic out_free;
  } seq_in_t;

  typedef struct packed {
    logic     in_ready;
    mul_sel_t mul_sel;
    logic     sat_coll;
    logic     sat_vel;
    logic     sat_damp;
    logic     upd_pos;
    logic     load_out;
  } ctl_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > SAT_HI) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Q16.16 product back to Q16.16 scale (floor), widened for saturation
  function automatic logic signed [50:0] qscale(input logic signed [64:0] p);
    return $signed({{2{p[64]}}, p[64:16]});
  endfunction

endpackage

// ===== sv/fhc_cfg.sv =====
// ----------------------------------------------------------------------------
// Falling hammer contact step: configuration registers
// Holds the seven physics registers written through the config channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhc_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output fhc_pkg::cfg_t cfg
);
  import fhc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_mass   <= RST_INVERSE_MASS;
      cfg.gravity        <= RST_GRAVITY;
      cfg.damping        <= RST_DAMPING;
      cfg.hardness       <= RST_HARDNESS;
      cfg.drop_height    <= RST_DROP_HEIGHT;
      cfg.start_velocity <= RST_START_VELOCITY;
      cfg.impact_limit   <= RST_IMPACT_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INVERSE_MASS:   cfg.inverse_mass   <= cfg_data[30:0];
        REG_GRAVITY:        cfg.gravity        <= $signed(cfg_data);
        REG_DAMPING:        cfg.damping        <= cfg_data[16:0];
        REG_HARDNESS:       cfg.hardness       <= cfg_data[30:0];
        REG_DROP_HEIGHT:    cfg.drop_height    <= $signed(cfg_data);
        REG_START_VELOCITY: cfg.start_velocity <= $signed(cfg_data);
        REG_IMPACT_LIMIT:   cfg.impact_limit   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/fhc_mul.sv =====
// ----------------------------------------------------------------------------
// Falling hammer contact step: shared multiplier
// One signed 33x32 multiplier with a registered 65-bit product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhc_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [31:0] b,
  output logic signed [64:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 65'(a) * 65'(b);
  end

endmodule

// ===== sv/fhc_seq.sv =====
// ----------------------------------------------------------------------------
// Falling hammer contact step: sequencer
// Steps a running tick through multiplies, saturations and position update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhc_seq (
  input  logic             clk,
  input  logic             rst,
  input  fhc_pkg::seq_in_t sin,
  output fhc_pkg::ctl_t    ctl
);
  import fhc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sin.accept) begin
          state_next = sin.tick_run ? S_MUL_COLL : S_DONE;
        end
      end
      S_MUL_COLL: state_next = S_SAT_COLL;
      S_SAT_COLL: state_next = S_MUL_MASS;
      S_MUL_MASS: state_next = S_SAT_VEL;
      S_SAT_VEL:  state_next = S_MUL_DAMP;
      S_MUL_DAMP: state_next = S_SAT_DAMP;
      S_SAT_DAMP: state_next = S_POS;
      S_POS:      state_next = S_DONE;
      S_DONE: begin
        if (sin.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.mul_sel  = MUL_COLL;
    case (state)
      S_IDLE:     ctl.in_ready = 1'b1;
      S_MUL_COLL: ctl.mul_sel  = MUL_COLL;
      S_SAT_COLL: ctl.sat_coll = 1'b1;
      S_MUL_MASS: ctl.mul_sel  = MUL_MASS;
      S_SAT_VEL:  ctl.sat_vel  = 1'b1;
      S_MUL_DAMP: ctl.mul_sel  = MUL_DAMP;
      S_SAT_DAMP: ctl.sat_damp = 1'b1;
      S_POS:      ctl.upd_pos  = 1'b1;
      S_DONE:     ctl.load_out = sin.out_free;
      default: ;
    endcase
  end

endmodule

// ===== sv/falling_hammer_contact_step.sv =====
// ----------------------------------------------------------------------------
// Falling hammer contact step: top level
// Q16.16 mass-spring hammer against a moving surface, one step per item.
//
// Input channel in_valid/in_ready/in_data: func 1 drops the hammer from
// drop_height, func 0 advances one time step against surface_position.
// Every item gives exactly one result on out_valid/out_ready/out_data.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data is always ready;
// write it only while no item is in flight.
// A running time step uses the one shared multiplier three times, each
// product followed by a saturation state, plus a position update, before
// the result is loaded. A drop or a step while stopped skips these and goes
// straight to the result; either way the next item is taken only after the
// result has moved into the output register.
// in_ready is high only while the sequencer is idle. The result sits in an
// output register; a stalled receiver holds it, and the block waits in its
// final cycle until the register frees up, so it never drops a result.
// Reset loads the default registers, puts the hammer at 20.0, stopped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "falling_hammer_contact_step_assert.svh"

module falling_hammer_contact_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fhc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fhc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import fhc_pkg::*;

  cfg_t    cfg;
  ctl_t    ctl;
  seq_in_t sin;

  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic               contact;
  logic [23:0]        impact_counter;
  logic               running;

  logic signed [32:0] diff;
  logic signed [31:0] coll;
  logic signed [31:0] vtmp;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;

  logic               accept;
  logic               enter;
  logic               leave;
  logic               contact_step;
  logic [23:0]        count_step;
  logic signed [50:0] vel_sum;
  logic signed [50:0] pos_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctl.in_ready;
  assign accept    = in_valid && ctl.in_ready;

  assign sin.accept   = accept;
  assign sin.tick_run = !in_data.func && running;
  assign sin.out_free = !out_valid || out_ready;

  fhc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fhc_seq u_seq (
    .clk (clk),
    .rst (rst),
    .sin (sin),
    .ctl (ctl)
  );

  always_comb begin
    case (ctl.mul_sel)
      MUL_MASS: begin
        mul_a = {coll[31], coll};
        mul_b = $signed({1'b0, cfg.inverse_mass});
      end
      MUL_DAMP: begin
        mul_a = {vtmp[31], vtmp};
        mul_b = $signed({15'd0, cfg.damping});
      end
      default: begin
        mul_a = diff;
        mul_b = $signed({1'b0, cfg.hardness});
      end
    endcase
  end

  fhc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // contact decisions against the pre-step position
  always_comb begin
    enter        = !contact && (position < in_data.surface_position);
    leave        = (contact || enter) && (position > in_data.surface_position);
    contact_step = (contact || enter) && !leave;
    count_step   = impact_counter;
    if (leave && impact_counter != COUNT_MAX) begin
      count_step = impact_counter + 24'd1;
    end
  end

  assign vel_sum = $signed({{19{velocity[31]}}, velocity})
                 - $signed({{19{cfg.gravity[31]}}, cfg.gravity})
                 - qscale(prod);
  assign pos_sum = $signed({{19{position[31]}}, position})
                 + $signed({{19{velocity[31]}}, velocity});

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= RST_DROP_HEIGHT;
      velocity       <= '0;
      contact        <= 1'b0;
      impact_counter <= '0;
      running        <= 1'b0;
    end else begin
      if (accept) begin
        if (in_data.func) begin
          position       <= cfg.drop_height;
          velocity       <= cfg.start_velocity;
          impact_counter <= '0;
          running        <= 1'b1;
        end else if (running) begin
          contact        <= contact_step;
          impact_counter <= count_step;
          if (leave && count_step >= cfg.impact_limit) begin
            running <= 1'b0;
          end
        end
      end
      if (ctl.sat_damp) begin
        velocity <= sat32(qscale(prod));
      end
      if (ctl.upd_pos) begin
        position <= sat32(pos_sum);
      end
    end
  end

  // working registers of the step
  always_ff @(posedge clk) begin
    if (accept) begin
      diff <= $signed({position[31], position})
            - $signed({in_data.surface_position[31], in_data.surface_position});
      coll <= '0;
    end
    if (ctl.sat_coll) begin
      coll <= contact ? sat32(qscale(prod)) : 32'sd0;
    end
    if (ctl.sat_vel) begin
      vtmp <= sat32(vel_sum);
    end
  end

  // output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data.collision_force <= coll;
      out_data.hammer_position <= position;
      out_data.hammer_velocity <= velocity;
      out_data.in_contact      <= contact;
      out_data.impact_count    <= impact_counter;
      out_data.running         <= running;
    end
  end

  `FHC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready after accept")
  `FHC_ASSERT(a_stopped_holds, in_valid && in_ready && !in_data.func && !running |=> $stable(position) && $stable(velocity), "stopped hammer moved")
  `FHC_ASSERT(a_force_needs_contact, out_valid && out_data.collision_force != 32'sd0 |-> out_data.in_contact, "force without contact")
  `FHC_ASSERT(a_count_on_accept, !(in_valid && in_ready) |=> $stable(impact_counter), "counter moved without item")
  `FHC_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "output valid after reset")

endmodule

// ===== tb/sv/falling_hammer_contact_step_tb.sv =====
// ----------------------------------------------------------------------------
// Falling hammer contact step: testbench
// Feeds drops and time steps with random gaps on both channels, runs each
// item through a Q16.16 hammer predictor and checks every result field.
// Register settings change between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module falling_hammer_contact_step_tb;
  import fhc_pkg::*;

  localparam logic       FUNC_TICK      = 1'b0;
  localparam logic       FUNC_DROP      = 1'b1;
  localparam logic [2:0] REG_UNUSED     = 3'd7;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_ITEMS   = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  wire in_fire  = in_valid & in_ready;
  wire out_fire = out_valid & out_ready;

  falling_hammer_contact_step DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // hammer model: settings and state
  cfg_t               settings;
  logic signed [31:0] ham_pos;
  logic signed [31:0] ham_vel;
  logic               ham_touching;
  logic [23:0]        ham_impacts;
  logic               ham_running;

  in_item_t  steps_to_send [$];
  out_item_t expected_steps [$];

  bit          steady = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int          quiet_cycles = 0;
  int          errors = 0;
  int          queued_count = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int          drops = 0;
  int          ticks = 0;
  int          contact_steps = 0;
  int          impacts = 0;
  int          stops = 0;
  int          phases = 0;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, floor on the dropped fraction
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic out_item_t hammer_step(input in_item_t it);
    longint    surf;
    longint    pos;
    longint    coll;
    longint    v;
    out_item_t r;
    surf = longint'($signed(it.surface_position));
    pos  = longint'(ham_pos);
    coll = 0;
    if (it.func == FUNC_DROP) begin
      ham_pos     = settings.drop_height;
      ham_vel     = settings.start_velocity;
      ham_impacts = '0;
      ham_running = 1'b1;
      drops++;
    end else begin
      ticks++;
      if (ham_running) begin
        if (!ham_touching && pos < surf) ham_touching = 1'b1;
        if (ham_touching && pos > surf) begin
          ham_touching = 1'b0;
          if (ham_impacts != COUNT_MAX) ham_impacts++;
          impacts++;
          if (ham_impacts >= settings.impact_limit) begin
            ham_running = 1'b0;
            stops++;
          end
        end
        if (ham_touching)
          coll = clamp32(fx_mul(pos - surf, longint'(settings.hardness)));
        v = clamp32(longint'(ham_vel) - longint'($signed(settings.gravity))
                    - fx_mul(coll, longint'(settings.inverse_mass)));
        v = clamp32(fx_mul(v, longint'(settings.damping)));
        ham_vel = 32'(v);
        ham_pos = 32'(clamp32(pos + v));
      end
    end
    if (ham_touching) contact_steps++;
    r.collision_force = 32'(coll);
    r.hammer_position = ham_pos;
    r.hammer_velocity = ham_vel;
    r.in_contact      = ham_touching;
    r.impact_count    = ham_impacts;
    r.running         = ham_running;
    return r;
  endfunction

  // sender: one item at a time, random gap before the next
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_fire) begin
      if (in_fire) expected_steps.push_back(hammer_step(in_data));
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        in_valid  <= 1'b0;
      end else if (steps_to_send.size() != 0) begin
        in_data   <= steps_to_send.pop_front();
        in_valid  <= 1'b1;
        send_wait <= steady ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
    errors++;
  endtask

  // receiver: check each result, then stall at random
  always @(posedge clk) begin : receive
    int unsigned stall;
    out_item_t   want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (out_fire) begin
      results_seen++;
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want = expected_steps.pop_front();
        if (out_data.collision_force !== want.collision_force)
          flag_field("collision_force", want.collision_force, out_data.collision_force);
        if (out_data.hammer_position !== want.hammer_position)
          flag_field("hammer_position", want.hammer_position, out_data.hammer_position);
        if (out_data.hammer_velocity !== want.hammer_velocity)
          flag_field("hammer_velocity", want.hammer_velocity, out_data.hammer_velocity);
        if (out_data.in_contact !== want.in_contact)
          flag_field("in_contact", 32'(want.in_contact), 32'(out_data.in_contact));
        if (out_data.impact_count !== want.impact_count)
          flag_field("impact_count", 32'(want.impact_count), 32'(out_data.impact_count));
        if (out_data.running !== want.running)
          flag_field("running", 32'(want.running), 32'(out_data.running));
      end
      stall = steady ? 0 : $urandom_range(0, 4);
      recv_wait <= stall;
      out_ready <= (stall == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || in_fire || out_fire || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("falling_hammer_contact_step: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic f, input logic signed [31:0] s);
    steps_to_send.push_back('{func: f, surface_position: s});
    queued_count++;
  endtask

  // drop, then ticks against a wandering surface with the odd wild sample
  task automatic queue_flight(input int n);
    logic signed [31:0] surf;
    surf = $signed($urandom_range(0, 131072)) - 65536;
    queue_item(FUNC_DROP, $urandom);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) begin
        queue_item(FUNC_TICK, $urandom);
      end else begin
        surf = surf + ($signed($urandom_range(0, 16384)) - 8192);
        queue_item(FUNC_TICK, surf);
      end
    end
  endtask

  // hold until the block is empty, return on a rising edge
  task automatic wait_idle();
    do @(negedge clk);
    while (steps_to_send.size() != 0 || in_valid || expected_steps.size() != 0
           || !in_ready || out_valid);
    @(posedge clk);
  endtask

  // write every register; call on a rising edge with the block idle
  task automatic apply_settings(input cfg_t c, input bit poke_unused);
    logic [2:0]  idx [$];
    logic [31:0] val [$];
    idx = '{REG_INVERSE_MASS, REG_GRAVITY, REG_DAMPING, REG_HARDNESS,
            REG_DROP_HEIGHT, REG_START_VELOCITY, REG_IMPACT_LIMIT};
    val = '{{1'b0, c.inverse_mass}, c.gravity, {15'b0, c.damping},
            {1'b0, c.hardness}, c.drop_height, c.start_velocity,
            {8'b0, c.impact_limit}};
    if (poke_unused) begin
      idx.push_back(REG_UNUSED);
      val.push_back($urandom);
    end
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk);
      while (!cfg_ready);
      case (idx[i])
        REG_INVERSE_MASS:   settings.inverse_mass   = val[i][30:0];
        REG_GRAVITY:        settings.gravity        = val[i];
        REG_DAMPING:        settings.damping        = val[i][16:0];
        REG_HARDNESS:       settings.hardness       = val[i][30:0];
        REG_DROP_HEIGHT:    settings.drop_height    = val[i];
        REG_START_VELOCITY: settings.start_velocity = val[i];
        REG_IMPACT_LIMIT:   settings.impact_limit   = val[i][23:0];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
    phases++;
  endtask

  // mostly a bouncing hammer that stops after a few impacts, now and then wild
  function automatic cfg_t random_settings();
    cfg_t c;
    c.inverse_mass = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                 : 31'($urandom_range(3277, 32768));
    c.gravity = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(6554, 65536);
    c.damping = ($urandom_range(0, 7) == 0) ? 17'($urandom)
                                            : 17'($urandom_range(62000, 65536));
    c.hardness = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                             : 31'($urandom_range(32768, 524288));
    c.drop_height = ($urandom_range(0, 7) == 0) ? $urandom
                                                : $urandom_range(65536, 655360);
    c.start_velocity = ($urandom_range(0, 3) == 0)
                       ? $signed($urandom_range(0, 131072)) - 65536 : 0;
    case ($urandom_range(0, 15))
      0:       c.impact_limit = '0;
      1, 2:    c.impact_limit = 24'($urandom);
      default: c.impact_limit = 24'($urandom_range(1, 6));
    endcase
    return c;
  endfunction

  initial begin
    int start_count;
    int phase_end;
    settings = '{inverse_mass: RST_INVERSE_MASS, gravity: RST_GRAVITY,
                 damping: RST_DAMPING, hardness: RST_HARDNESS,
                 drop_height: RST_DROP_HEIGHT, start_velocity: RST_START_VELOCITY,
                 impact_limit: RST_IMPACT_LIMIT};
    ham_pos      = RST_DROP_HEIGHT;
    ham_vel      = '0;
    ham_touching = 1'b0;
    ham_impacts  = '0;
    ham_running  = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: ticks while stopped, a fall into contact, far surfaces
    @(negedge clk);
    queue_item(FUNC_TICK, 32'sd0);
    queue_item(FUNC_TICK, 32'sh7FFFFFFF);
    queue_item(FUNC_DROP, 32'sh80000000);
    repeat (8) queue_item(FUNC_TICK, 32'sd0);
    queue_item(FUNC_TICK, 32'sh7FFFFFFF);
    queue_item(FUNC_TICK, 32'sh80000000);
    queue_item(FUNC_TICK, 32'sd0);
    queue_item(FUNC_DROP, 32'sh7FFFFFFF);
    queue_item(FUNC_TICK, 32'sd0);
    wait_idle();

    // top of most ranges, start velocity at its bottom: damping above 1.0, limit zero stops on first impact
    apply_settings('{inverse_mass: 31'h7FFFFFFF, gravity: 32'sh7FFFFFFF,
                     damping: 17'h1FFFF, hardness: 31'h7FFFFFFF,
                     drop_height: 32'sh7FFFFFFF, start_velocity: 32'sh80000000,
                     impact_limit: 24'h0}, 1'b1);
    @(negedge clk);
    queue_item(FUNC_DROP, 32'sd0);
    queue_item(FUNC_TICK, 32'sh7FFFFFFF);
    queue_item(FUNC_TICK, 32'sd0);
    queue_item(FUNC_TICK, 32'sh80000000);
    queue_item(FUNC_TICK, 32'sd0);
    wait_idle();

    // bottom of most ranges; start velocity and impact limit at their top
    apply_settings('{inverse_mass: 31'h0, gravity: 32'sh80000000, damping: 17'h0,
                     hardness: 31'h0, drop_height: 32'sh80000000,
                     start_velocity: 32'sh7FFFFFFF, impact_limit: 24'hFFFFFF}, 1'b0);
    @(negedge clk);
    queue_item(FUNC_DROP, 32'sh80000000);
    queue_item(FUNC_TICK, 32'sh80000000);
    queue_item(FUNC_TICK, 32'sh7FFFFFFF);
    queue_item(FUNC_TICK, 32'sd0);
    wait_idle();

    // random phases; each ends with the sender held until all results are in
    start_count = queued_count;
    while (queued_count < start_count + RANDOM_ITEMS) begin
      apply_settings(random_settings(), $urandom_range(0, 3) == 0);
      steady = (phases % 4 == 3);
      @(negedge clk);
      phase_end = queued_count + $urandom_range(100, 200);
      while (queued_count < phase_end) queue_flight($urandom_range(0, 60));
      wait_idle();
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (expected_steps.size() != 0) begin
      $display("%0t: %0d results never arrived, first expected %h", $time,
               expected_steps.size(), expected_steps[0]);
      errors++;
    end
    $display("Covered %0d items (%0d drops, %0d ticks), %0d results, %0d register writes",
             queued_count, drops, ticks, results_seen, reg_writes);
    $display("in %0d setting phases: %0d contact steps, %0d impacts, %0d limit stops",
             phases, contact_steps, impacts, stops);
    if (errors == 0) begin
      $display("falling_hammer_contact_step: match");
    end else begin
      $display("falling_hammer_contact_step: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/fhc_pkg.sv
sv/fhc_cfg.sv
sv/fhc_mul.sv
sv/fhc_seq.sv
sv/falling_hammer_contact_step.sv
tb/sv/falling_hammer_contact_step_tb.sv
